// File: rtl/nts_pkg.sv
`default_nettype none

package nts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int STAMP_W     = 48;
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int PTR_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] frame_index;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_START  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/nts_ram.sv
`default_nettype none

module nts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/nts_search.sv
`default_nettype none

module nts_search (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic                         req_type,
  input  wire logic [nts_pkg::INDEX_W-1:0]  entry_index,
  input  wire logic [nts_pkg::STAMP_W-1:0]  stamp,
  input  wire logic [nts_pkg::STAMP_W-1:0]  match_limit,
  input  wire logic [nts_pkg::COUNT_W-1:0]  entry_count,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output nts_pkg::res_t                     res
);

  nts_pkg::state_t state_r, state_nxt;

  logic        [nts_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  logic signed [nts_pkg::PTR_W-1:0]   lo_r, lo_nxt;
  logic signed [nts_pkg::PTR_W-1:0]   hi_r, hi_nxt;
  logic        [nts_pkg::INDEX_W-1:0] mid_r, mid_nxt;
  logic        [nts_pkg::INDEX_W-1:0] best_r, best_nxt;
  logic        [nts_pkg::STAMP_W-1:0] best_gap_r, best_gap_nxt;
  logic                               best_valid_r, best_valid_nxt;

  logic        [nts_pkg::STAMP_W-1:0] entry;
  logic        [nts_pkg::STAMP_W-1:0] gap;
  logic                               entry_lt;
  logic        [nts_pkg::COUNT_W-1:0] count;
  logic signed [nts_pkg::PTR_W-1:0]   sum;
  logic        [nts_pkg::INDEX_W-1:0] raddr;
  logic                               we;
  logic                               accept;

  nts_ram #(
    .WIDTH (nts_pkg::STAMP_W),
    .DEPTH (nts_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (entry_index),
    .wdata (stamp),
    .raddr (raddr),
    .rdata (entry)
  );

  assign in_tready = (state_r == nts_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign we        = accept && (req_type == nts_pkg::REQ_WRITE);

  assign count = (entry_count > nts_pkg::COUNT_W'(nts_pkg::TABLE_DEPTH)) ?
                 nts_pkg::COUNT_W'(nts_pkg::TABLE_DEPTH) : entry_count;

  assign entry_lt = entry < stamp_r;
  assign gap      = entry_lt ? (stamp_r - entry) : (entry - stamp_r);

  always_comb begin
    state_nxt      = state_r;
    stamp_nxt      = stamp_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    best_nxt       = best_r;
    best_gap_nxt   = best_gap_r;
    best_valid_nxt = best_valid_r;
    res_valid      = 1'b0;

    case (state_r)
      nts_pkg::ST_IDLE: begin
        if (accept && (req_type == nts_pkg::REQ_QUERY)) begin
          stamp_nxt      = stamp;
          best_valid_nxt = 1'b0;
          state_nxt      = nts_pkg::ST_START;
        end
      end
      nts_pkg::ST_START: begin
        lo_nxt = '0;
        hi_nxt = $signed({1'b0, count}) - nts_pkg::PTR_W'(1);
        if (count == '0) begin
          state_nxt = nts_pkg::ST_FINISH;
        end else begin
          state_nxt = nts_pkg::ST_SEARCH;
        end
      end
      nts_pkg::ST_SEARCH: begin
        if (!best_valid_r || (gap < best_gap_r)) begin
          best_valid_nxt = 1'b1;
          best_gap_nxt   = gap;
          best_nxt       = mid_r;
        end
        if (entry_lt) begin
          lo_nxt = $signed({2'b00, mid_r}) + nts_pkg::PTR_W'(1);
        end else begin
          hi_nxt = $signed({2'b00, mid_r}) - nts_pkg::PTR_W'(1);
        end
        if (lo_nxt > hi_nxt) begin
          state_nxt = nts_pkg::ST_FINISH;
        end
      end
      nts_pkg::ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = nts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nts_pkg::ST_IDLE;
      end
    endcase

    sum   = lo_nxt + hi_nxt;
    raddr = sum[nts_pkg::INDEX_W:1];
    if (state_nxt == nts_pkg::ST_SEARCH) begin
      mid_nxt = raddr;
    end
  end

  always_comb begin
    res.found       = best_valid_r && (best_gap_r <= match_limit);
    res.frame_index = res.found ? best_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nts_pkg::ST_IDLE;
      best_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      best_valid_r <= best_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r    <= stamp_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    best_r     <= best_nxt;
    best_gap_r <= best_gap_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/nearest_timestamp_search.sv
// Nearest-timestamp lookup over a table of up to 1024 ascending 48-bit stamps.
// The input stream carries two kinds of transaction, chosen by in_tuser: a
// write stores in_tdata's stamp at entry_index and gives no result; a query
// looks up the stamp and gives exactly one result transaction.
// The configuration channel sets the match limit, the largest accepted
// time difference (index 0), and entry_count (index 1); it is always ready.
// It must be written only while the block is idle; this is not enforced.
// A query binary-searches the first entry_count entries (at most 1024), one
// table read per probe: a setup step in ST_START, one probe per step in
// ST_SEARCH (at most 11 probes, none on an empty table), then ST_FINISH hands
// the result to the output register. The input becomes ready again once that
// hand-over is made; a write leaves the block idle for the next item at once.
// The single table read port allows only one probe at a time.
// A result sits in the output register while the next item is accepted; if
// the receiver stalls with a result still held, a finished query waits in
// the engine and the input stays blocked until the register frees up.
// Reset (rst_n low, synchronous) returns the match limit to 100, entry_count
// to 0 and clears the handshake state; table contents are kept, and entries
// must be written before a query probes them.
`default_nettype none

module nearest_timestamp_search (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [9:0] entry_index, [57:10] stamp, [63:58] zero
  input  wire logic [nts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [9:0] frame_index, [15:10] zero
  output logic      [nts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] found
  output logic                                  out_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [nts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nts_pkg::STAMP_W-1:0]      cfg_data
);

  logic [nts_pkg::STAMP_W-1:0] match_limit_r;
  logic [nts_pkg::COUNT_W-1:0] entry_count_r;

  logic                        out_valid_r;
  nts_pkg::res_t               out_res_r;

  logic                        res_valid;
  logic                        res_ready;
  nts_pkg::res_t               res;

  nts_search u_search (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .req_type      (in_tuser),
    .entry_index   (in_tdata[nts_pkg::INDEX_W-1:0]),
    .stamp         (in_tdata[nts_pkg::INDEX_W +: nts_pkg::STAMP_W]),
    .match_limit   (match_limit_r),
    .entry_count   (entry_count_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_limit_r <= nts_pkg::STAMP_W'(100);
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nts_pkg::CFG_MATCH_LIMIT: match_limit_r <= cfg_data;
        nts_pkg::CFG_ENTRY_COUNT: entry_count_r <= cfg_data[nts_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = {{(nts_pkg::OUT_TDATA_W - nts_pkg::INDEX_W){1'b0}},
                       out_res_r.frame_index};

endmodule

`default_nettype wire
